@@ rtl/core/csb_pkg.sv @@
// Package for the counting semaphore bank: sizes, beat layouts, opcodes and status codes.
// No dependencies; imported by counting_semaphore_bank.
package csb_pkg;

    localparam int NUM_SEMS    = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int SLOT_W      = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int ENTRY_W     = 2 * COUNT_WIDTH;

    localparam int OP_W       = 2;
    localparam int ID_W       = 7;
    localparam int FIELD_W    = 16;
    localparam int STATUS_W   = 3;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [OP_W-1:0] {
        OP_CREATE = 2'd0,
        OP_WAIT   = 2'd1,
        OP_SIGNAL = 2'd2,
        OP_DELETE = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_BAD_ID      = 3'd1,
        ST_NOT_EXIST   = 3'd2,
        ST_NO_FREE     = 3'd3,
        ST_WOULD_BLOCK = 3'd4
    } status_t;

endpackage

@@ rtl/core/counting_semaphore_bank.sv @@
// Counting semaphore bank top level: active map in flops, count/max in one synchronous RAM.
// Depends on csb_pkg.
//
// channel | dir | beat contents (low bit first)
// s_*     | in  | tuser: operation[1:0]; tdata: sem_id[6:0], init_count[22:7], max_count[38:23]
// m_*     | out | tdata: status[2:0], new_id[9:3], count_after[25:10]
//
// One beat per cycle while m_tready is high; a beat passes the read stage, then the output stage.
// The RAM read issued at acceptance returns next cycle; the write-back of the item ahead
// is forwarded when it hits the same slot.
// Reset clears the active map and both stage valids; the RAM needs no clearing.
// With m_tready low the result holds and one more item waits in the read stage.
module counting_semaphore_bank
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [csb_pkg::IN_DATA_W-1:0]  s_tdata,   // sem_id, init_count, max_count, pad
    input  logic [csb_pkg::OP_W-1:0]       s_tuser,   // operation
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [csb_pkg::OUT_DATA_W-1:0] m_tdata    // status, new_id, count_after, pad
);
    import csb_pkg::*;

    logic [ENTRY_W-1:0]     mem [NUM_SEMS];
    logic [ENTRY_W-1:0]     rd_data_reg;

    logic                   s1_valid_reg, s1_valid_next;
    op_t                    s1_op_reg;
    logic [ID_W-1:0]        s1_id_reg;
    logic [FIELD_W-1:0]     s1_init_reg;
    logic [FIELD_W-1:0]     s1_max_reg;

    logic                   fwd_valid_reg, fwd_valid_next;
    logic [ENTRY_W-1:0]     fwd_data_reg;

    logic [NUM_SEMS-1:0]    active_reg, active_next;

    logic                   m_valid_reg, m_valid_next;
    status_t                m_status_reg;
    logic [ID_W-1:0]        m_id_reg;
    logic [FIELD_W-1:0]     m_count_reg;

    logic                   accept, adv;
    logic [ID_W-1:0]        in_id, in_id_m1, s1_id_m1;
    logic [SLOT_W-1:0]      in_slot, s1_slot;
    logic [ENTRY_W-1:0]     entry;
    logic [COUNT_WIDTH-1:0] cur_cnt, cur_max, new_cnt;
    logic                   found;
    logic [SLOT_W-1:0]      free_idx;
    logic                   bad_id;

    logic                   we;
    logic [SLOT_W-1:0]      waddr;
    logic [ENTRY_W-1:0]     wdata;
    status_t                res_status;
    logic [ID_W-1:0]        res_id;
    logic [COUNT_WIDTH-1:0] res_cnt;

    assign in_id    = s_tdata[ID_W-1:0];
    assign in_id_m1 = in_id - ID_W'(1);
    assign in_slot  = in_id_m1[SLOT_W-1:0];
    assign s1_id_m1 = s1_id_reg - ID_W'(1);
    assign s1_slot  = s1_id_m1[SLOT_W-1:0];

    assign adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign accept   = s_tvalid && s_tready;

    assign entry   = fwd_valid_reg ? fwd_data_reg : rd_data_reg;
    assign cur_cnt = entry[COUNT_WIDTH-1:0];
    assign cur_max = entry[ENTRY_W-1:COUNT_WIDTH];
    assign bad_id  = (s1_id_reg == '0) || (s1_id_reg > ID_W'(NUM_SEMS));

    // lowest inactive slot
    always_comb
    begin
        found    = 1'b0;
        free_idx = '0;
        for (int i = NUM_SEMS - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                found    = 1'b1;
                free_idx = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        we          = 1'b0;
        waddr       = s1_slot;
        wdata       = entry;
        new_cnt     = cur_cnt;
        active_next = active_reg;
        res_status  = ST_OK;
        res_id      = '0;
        res_cnt     = '0;
        if (s1_op_reg == OP_CREATE)
        begin
            if (found)
            begin
                we                    = 1'b1;
                waddr                 = free_idx;
                wdata                 = {COUNT_WIDTH'(s1_max_reg), COUNT_WIDTH'(s1_init_reg)};
                active_next[free_idx] = 1'b1;
                res_id                = ID_W'(free_idx) + ID_W'(1);
                res_cnt               = COUNT_WIDTH'(s1_init_reg);
            end
            else
            begin
                res_status = ST_NO_FREE;
            end
        end
        else if (bad_id)
        begin
            res_status = ST_BAD_ID;
        end
        else if (s1_op_reg == OP_DELETE)
        begin
            active_next[s1_slot] = 1'b0;
        end
        else if (!active_reg[s1_slot])
        begin
            res_status = ST_NOT_EXIST;
        end
        else if (s1_op_reg == OP_WAIT)
        begin
            if (cur_cnt != '0)
            begin
                new_cnt = cur_cnt - COUNT_WIDTH'(1);
                we      = 1'b1;
                wdata   = {cur_max, new_cnt};
                res_cnt = new_cnt;
            end
            else
            begin
                res_status = ST_WOULD_BLOCK;
            end
        end
        else
        begin
            if (cur_cnt < cur_max)
            begin
                new_cnt = cur_cnt + COUNT_WIDTH'(1);
                we      = 1'b1;
                wdata   = {cur_max, new_cnt};
            end
            res_cnt = new_cnt;
        end
        if (!adv)
        begin
            we          = 1'b0;
            active_next = active_reg;
        end
    end

    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_reg);
        fwd_valid_next = accept ? (we && (waddr == in_slot)) : (adv ? 1'b0 : fwd_valid_reg);
        m_valid_next   = adv ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[in_slot];
        end
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            active_reg    <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            m_valid_reg   <= m_valid_next;
            active_reg    <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg    <= op_t'(s_tuser);
            s1_id_reg    <= in_id;
            s1_init_reg  <= s_tdata[ID_W +: FIELD_W];
            s1_max_reg   <= s_tdata[ID_W + FIELD_W +: FIELD_W];
            fwd_data_reg <= wdata;
        end
        if (adv)
        begin
            m_status_reg <= res_status;
            m_id_reg     <= res_id;
            m_count_reg  <= FIELD_W'(res_cnt);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - STATUS_W - ID_W - FIELD_W){1'b0}},
                       m_count_reg, m_id_reg, m_status_reg};

`ifndef NO_ASSERTIONS
    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forward flag set with empty read stage");

    a_write_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> adv)
        else $error("RAM write without stage advance");

    a_id_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (m_id_reg == '0 || m_status_reg == ST_OK))
        else $error("new_id set on failed request");

    a_err_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_status_reg != ST_OK) |-> (m_count_reg == '0))
        else $error("count_after nonzero on error");

    a_create_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_op_reg == OP_CREATE && found) |=> active_reg[$past(free_idx)])
        else $error("created slot not active");
`endif

endmodule
